// File: rtl/msic_pkg.sv
`default_nettype none
package msic_pkg;

    // Store geometry and field widths
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 39;
    localparam int ECNT_W  = 21;

    // Memory access request from the merge engine
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              src_a;
    } msic_mem_req_t;

    // Merge engine status toward the top level
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } msic_status_t;

endpackage
`default_nettype wire

// File: rtl/msic_ram.sv
`default_nettype none
module msic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/msic_merge.sv
`default_nettype none
module msic_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [msic_pkg::FILL_W-1:0] n,
    input  wire logic [msic_pkg::DATA_W-1:0] rd_data,
    output msic_pkg::msic_mem_req_t          req,
    output msic_pkg::msic_status_t           status
);
    import msic_pkg::*;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_FETCH_A = 8'b0000_0010,
        M_FETCH_B = 8'b0000_0100,
        M_WAIT_B  = 8'b0000_1000,
        M_MERGE   = 8'b0001_0000,
        M_REFILL  = 8'b0010_0000,
        M_NEXT    = 8'b0100_0000,
        M_DONE    = 8'b1000_0000
    } msic_mstate_t;

    msic_mstate_t      state_reg, state_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [FILL_W-1:0] width_reg, width_next;
    logic [FILL_W-1:0] lo_reg, lo_next;
    logic [FILL_W-1:0] mid_reg, mid_next;
    logic [FILL_W-1:0] hi_reg, hi_next;
    logic [FILL_W-1:0] a_reg, a_next;
    logic [FILL_W-1:0] b_reg, b_next;
    logic [FILL_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              src_a_reg, src_a_next;
    logic              took_a_reg, took_a_next;
    logic [DATA_W-1:0] head_a_reg, head_a_next;
    logic [DATA_W-1:0] head_b_reg, head_b_next;

    logic [FILL_W-1:0] rem;
    logic [FILL_W:0]   width2;
    logic [FILL_W:0]   lo_sum;
    logic [FILL_W-1:0] run_mid;
    logic [FILL_W-1:0] run_hi;
    logic              take_a;
    logic [FILL_W-1:0] a_inc;
    logic [FILL_W-1:0] b_inc;

    // Run bounds, merge choice and index increments for the current pair of runs
    always_comb
    begin
        rem     = n_reg - lo_reg;
        width2  = {width_reg, 1'b0};
        lo_sum  = {1'b0, lo_reg} + width2;
        run_mid = ({1'b0, rem} > {1'b0, width_reg}) ? (lo_reg + width_reg) : n_reg;
        run_hi  = ({1'b0, rem} > width2) ? lo_sum[FILL_W-1:0] : n_reg;
        take_a  = (b_reg >= hi_reg)
                  || ((a_reg < mid_reg) && ($signed(head_a_reg) <= $signed(head_b_reg)));
        a_inc   = a_reg + 1'b1;
        b_inc   = b_reg + 1'b1;
    end

    // Sequence the merge passes
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        src_a_next  = src_a_reg;
        took_a_next = took_a_reg;
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        req.rd_addr = a_reg[ADDR_W-1:0];
        req.wr_en   = 1'b0;
        req.wr_addr = k_reg[ADDR_W-1:0];
        req.wr_data = take_a ? head_a_reg : head_b_reg;
        req.src_a   = src_a_reg;
        status.done = (state_reg == M_DONE);
        status.count = count_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    n_next     = n;
                    width_next = {{(FILL_W-1){1'b0}}, 1'b1};
                    lo_next    = '0;
                    count_next = '0;
                    src_a_next = 1'b1;
                    state_next = (n > {{(FILL_W-1){1'b0}}, 1'b1}) ? M_FETCH_A : M_DONE;
                end
            end
            M_FETCH_A:
            begin
                // Latch run bounds and read the left head
                mid_next    = run_mid;
                hi_next     = run_hi;
                a_next      = lo_reg;
                b_next      = run_mid;
                k_next      = lo_reg;
                req.rd_addr = lo_reg[ADDR_W-1:0];
                state_next  = M_FETCH_B;
            end
            M_FETCH_B:
            begin
                head_a_next = rd_data;
                req.rd_addr = b_reg[ADDR_W-1:0];
                state_next  = M_WAIT_B;
            end
            M_WAIT_B:
            begin
                head_b_next = rd_data;
                state_next  = M_MERGE;
            end
            M_MERGE:
            begin
                // Write the smaller head, fetch its successor
                req.wr_en   = 1'b1;
                k_next      = k_reg + 1'b1;
                took_a_next = take_a;
                if (take_a)
                begin
                    a_next      = a_inc;
                    req.rd_addr = a_inc[ADDR_W-1:0];
                end
                else
                begin
                    b_next      = b_inc;
                    req.rd_addr = b_inc[ADDR_W-1:0];
                    count_next  = count_reg + {{(CNT_W-FILL_W){1'b0}}, mid_reg - a_reg};
                end
                state_next = ((k_reg + 1'b1) == hi_reg) ? M_NEXT : M_REFILL;
            end
            M_REFILL:
            begin
                if (took_a_reg)
                begin
                    head_a_next = rd_data;
                end
                else
                begin
                    head_b_next = rd_data;
                end
                state_next = M_MERGE;
            end
            M_NEXT:
            begin
                // Advance to the next pair or the next pass, or finish after the last pass
                if (lo_sum >= {1'b0, n_reg})
                begin
                    lo_next    = '0;
                    src_a_next = !src_a_reg;
                    width_next = width2[FILL_W-1:0];
                    state_next = (width2 >= {1'b0, n_reg}) ? M_DONE : M_FETCH_A;
                end
                else
                begin
                    lo_next    = lo_sum[FILL_W-1:0];
                    state_next = M_FETCH_A;
                end
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            count_reg <= '0;
            src_a_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            src_a_reg <= src_a_next;
        end
    end

    // Indexes and heads
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        took_a_reg <= took_a_next;
        head_a_reg <= head_a_next;
        head_b_reg <= head_b_next;
    end

endmodule
`default_nettype wire

// File: rtl/merge_sort_inversion_counter_core.sv
// Load: one word per cycle into the element store; in_stall is low while loading.
// Count: bottom-up merge passes through one read port of the source store; each
//   run pair fetches both heads, then alternates merge and refill steps.
// Result: loaded into the output register when free, then held until taken.
// Reset clears control, counters and flags, not the stores or result registers.
`default_nettype none
module merge_sort_inversion_counter_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [msic_pkg::DATA_W-1:0] value,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [msic_pkg::CNT_W-1:0]  inversion_count,
    output logic      [msic_pkg::ECNT_W-1:0] element_count,
    output logic                             overflow
);
    import msic_pkg::*;

    typedef enum logic [3:0] {
        T_LOAD  = 4'b0001,
        T_START = 4'b0010,
        T_COUNT = 4'b0100,
        T_OUT   = 4'b1000
    } msic_tstate_t;

    msic_tstate_t      state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              dropped_reg, dropped_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  inv_reg, inv_next;
    logic [ECNT_W-1:0] ecnt_reg, ecnt_next;
    logic              ovf_reg, ovf_next;

    msic_mem_req_t     req;
    msic_status_t      status;
    logic              accept;
    logic              room;
    logic              load_we;
    logic              a_we;
    logic [ADDR_W-1:0] a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic [DATA_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;
    logic              slot_free;

    assign in_stall  = (state_reg != T_LOAD);
    assign accept    = in_valid && !in_stall;
    assign room      = (fill_reg < FILL_W'(DEPTH));
    assign load_we   = accept && room;
    assign slot_free = !out_valid_reg || !out_stall;

    // Route store ports between loading and merging
    always_comb
    begin
        if (state_reg == T_LOAD)
        begin
            a_we    = load_we;
            a_waddr = fill_reg[ADDR_W-1:0];
            a_wdata = value;
        end
        else
        begin
            a_we    = req.wr_en && !req.src_a;
            a_waddr = req.wr_addr;
            a_wdata = req.wr_data;
        end
    end

    msic_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_element_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (req.rd_addr),
        .rdata (a_rdata)
    );

    msic_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_merge_scratch (
        .clk   (clk),
        .we    (req.wr_en && req.src_a),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .raddr (req.rd_addr),
        .rdata (b_rdata)
    );

    msic_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == T_START),
        .n       (fill_reg),
        .rd_data (req.src_a ? a_rdata : b_rdata),
        .req     (req),
        .status  (status)
    );

    // Sequence load, count and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && out_stall;
        inv_next       = inv_reg;
        ecnt_next      = ecnt_reg;
        ovf_next       = ovf_reg;

        case (state_reg)
            T_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = T_START;
                    end
                end
            end
            T_START:
            begin
                state_next = T_COUNT;
            end
            T_COUNT:
            begin
                if (status.done)
                begin
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                // Hand the result to the output register, then start a new sequence
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    inv_next       = status.count;
                    ecnt_next      = ECNT_W'(fill_reg);
                    ovf_next       = dropped_reg;
                    fill_next      = '0;
                    dropped_next   = 1'b0;
                    state_next     = T_LOAD;
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_LOAD;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        inv_reg  <= inv_next;
        ecnt_reg <= ecnt_next;
        ovf_reg  <= ovf_next;
    end

    assign out_valid       = out_valid_reg;
    assign inversion_count = inv_reg;
    assign element_count   = ecnt_reg;
    assign overflow        = ovf_reg;

endmodule
`default_nettype wire
